[rtl/core/thse_pkg.sv]
// Shared types, constants and the panel digit encoder for the segment encoder.
`default_nettype none

package thse_pkg;

    typedef enum logic [1:0] {
        CMD_SHOW    = 2'd0,
        CMD_BATTERY = 2'd1,
        CMD_LINK    = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] temperature_tenths;
        logic [7:0]         humidity;
        logic               icon_on;
    } item_t;

    typedef logic [5:0][7:0] frame_t;

    localparam logic [7:0] ERR_BYTE_0   = 8'hF2;
    localparam logic [7:0] ERR_BYTE_1   = 8'h42;
    localparam logic [7:0] MINUS_MARK   = 8'h02;
    localparam logic [7:0] THOUSAND_MARK = 8'h08;
    localparam logic [7:0] UNIT_MARK    = 8'h40;
    localparam int unsigned BATTERY_BIT = 5;
    localparam int unsigned LINK_BIT    = 3;

    // Standard gfedcba segments of a decimal digit.
    function automatic logic [6:0] std_segments(input logic [3:0] digit);
        logic [6:0] s;
        case (digit)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h3F;
        endcase
        return s;
    endfunction

    // The panel wires segments a..g to bits 4,0,2,7,6,5,1 and the point to bit 3.
    function automatic logic [7:0] panel_digit(input logic [3:0] digit, input logic point);
        logic [6:0] s;
        logic [7:0] b;
        s = std_segments(digit);
        b = {s[3], s[4], s[5], s[0], point, s[2], s[6], s[1]};
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/core/temp_humidity_segment_encoder.sv]
// Top level of the temperature and humidity seven-segment frame encoder.
// Usage: an item (command, temperature_tenths, humidity, icon_on) enters on the
// item channel and is taken at a rising edge where item_valid is high and
// item_stall is low. Each item yields exactly one result item on the result
// channel: the whole six-byte segment frame after the item plus the changed flag.
// The item first lands in an input register; the frame logic then computes the
// new frame from it and loads it into the frame register, which is both the
// display state and the result register. result_valid is registered and rises
// with that load, and while result_stall is low one item can be accepted in
// every cycle.
// The rate is set by the single frame register, which is read and rewritten
// once per item.
// When the receiver raises result_stall, the result holds steady and the input
// register keeps its item; item_stall rises only once that register is full
// and cannot drain, so one item can still enter while a result waits.
// Reset clears the frame to all zeros, clears both valid flags and drops the
// changed flag.
`default_nettype none

module temp_humidity_segment_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  command,
    input  logic signed [15:0] temperature_tenths,
    input  logic [7:0]  humidity,
    input  logic        icon_on,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  frame_byte_0,
    output logic [7:0]  frame_byte_1,
    output logic [7:0]  frame_byte_2,
    output logic [7:0]  frame_byte_3,
    output logic [7:0]  frame_byte_4,
    output logic [7:0]  frame_byte_5,
    output logic        changed
);

    thse_pkg::item_t  item_reg;
    logic             item_valid_reg;
    thse_pkg::frame_t frame_reg;
    thse_pkg::frame_t frame_next;
    logic             changed_reg;
    logic             changed_next;
    logic             result_valid_reg;
    logic             result_open;
    logic             advance;
    logic             take_item;

    // The result register can load when it is empty or being drained now.
    assign result_open = !result_valid_reg || !result_stall;
    assign advance     = item_valid_reg && result_open;
    assign item_stall  = item_valid_reg && !result_open;
    assign take_item   = item_valid && !item_stall;

    thse_calc u_calc (
        .item         (item_reg),
        .frame        (frame_reg),
        .frame_next   (frame_next),
        .changed_next (changed_next)
    );

    // Input register: payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            item_reg.command            <= command;
            item_reg.temperature_tenths <= temperature_tenths;
            item_reg.humidity           <= humidity;
            item_reg.icon_on            <= icon_on;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (take_item)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    // The frame register is the panel state and also the result payload; it only
    // changes when a result is loaded, so a stalled result stays put.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg        <= '0;
            changed_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                frame_reg   <= frame_next;
                changed_reg <= changed_next;
            end
            if (result_open)
            begin
                result_valid_reg <= advance;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign frame_byte_0 = frame_reg[0];
    assign frame_byte_1 = frame_reg[1];
    assign frame_byte_2 = frame_reg[2];
    assign frame_byte_3 = frame_reg[3];
    assign frame_byte_4 = frame_reg[4];
    assign frame_byte_5 = frame_reg[5];
    assign changed      = changed_reg;

endmodule

`default_nettype wire

[rtl/core/thse_calc.sv]
// Combinational next-frame logic for one item of the segment encoder.
`default_nettype none

module thse_calc (
    input  var thse_pkg::item_t  item,
    input  var thse_pkg::frame_t frame,
    output var thse_pkg::frame_t frame_next,
    output logic                 changed_next
);

    logic signed [15:0] t;
    logic               out_of_range;
    logic               neg;
    logic               big;
    logic [15:0]        mag_full;
    logic [10:0]        mag;
    logic [23:0]        q10_prod;
    logic [23:0]        q100_prod;
    logic [7:0]         q10;
    logic [4:0]         q100;
    logic [7:0]         tens_diff;
    logic [10:0]        units_diff;
    logic [3:0]         tens;
    logic [3:0]         units;
    logic [3:0]         hundreds;
    logic [6:0]         hum_sat;
    logic [14:0]        htens_prod;
    logic [3:0]         htens;
    logic [6:0]         hunits_diff;
    logic [7:0]         temp_b0;
    logic [7:0]         temp_b1;
    logic [7:0]         temp_b2;
    thse_pkg::frame_t   show_frame;
    logic               battery_now;
    logic               link_now;

    assign t            = item.temperature_tenths;
    assign out_of_range = (t < -16'sd99) || (t > 16'sd1999);
    assign neg          = t[15];
    assign big          = (t >= 16'sd1000);
    assign mag_full     = neg ? 16'(-t) : 16'(t);
    assign mag          = mag_full[10:0];

    // Reciprocal multiplies, exact for magnitudes up to 1999.
    assign q10_prod    = 24'(mag) * 24'd6554;
    assign q100_prod   = 24'(mag) * 24'd5243;
    assign q10         = q10_prod[23:16];
    assign q100        = q100_prod[23:19];
    assign tens_diff   = q10 - 8'(8'(q100) * 8'd10);
    assign units_diff  = mag - 11'(11'(q10) * 11'd10);
    assign tens        = tens_diff[3:0];
    assign units       = units_diff[3:0];
    assign hundreds    = (q100 >= 5'd10) ? 4'(q100 - 5'd10) : q100[3:0];

    assign hum_sat     = (item.humidity > 8'd99) ? 7'd99 : item.humidity[6:0];
    assign htens_prod  = 15'(hum_sat) * 15'd205;
    assign htens       = htens_prod[14:11];
    assign hunits_diff = hum_sat - 7'(7'(htens) * 7'd10);

    always_comb
    begin
        if (out_of_range)
        begin
            temp_b0 = thse_pkg::ERR_BYTE_0;
            temp_b1 = thse_pkg::ERR_BYTE_1;
            temp_b2 = 8'h00;
        end
        else
        begin
            if (neg)
            begin
                temp_b0 = thse_pkg::MINUS_MARK;
            end
            else if (big)
            begin
                temp_b0 = thse_pkg::panel_digit(hundreds, 1'b0) | thse_pkg::THOUSAND_MARK;
            end
            else if (q100 != 5'd0)
            begin
                temp_b0 = thse_pkg::panel_digit(hundreds, 1'b0);
            end
            else
            begin
                temp_b0 = 8'h00;
            end
            temp_b1 = thse_pkg::panel_digit(tens, units != 4'd0);
            temp_b2 = (units != 4'd0) ? thse_pkg::panel_digit(units, 1'b1) : 8'h00;
        end
    end

    always_comb
    begin
        show_frame    = '0;
        show_frame[0] = temp_b0;
        show_frame[1] = temp_b1;
        show_frame[2] = temp_b2;
        show_frame[3] = thse_pkg::UNIT_MARK;
        show_frame[3][thse_pkg::BATTERY_BIT] = frame[3][thse_pkg::BATTERY_BIT];
        show_frame[4] = thse_pkg::panel_digit(htens, 1'b0);
        show_frame[4][thse_pkg::LINK_BIT] = frame[4][thse_pkg::LINK_BIT];
        show_frame[5] = thse_pkg::panel_digit(hunits_diff[3:0], 1'b1);
    end

    assign battery_now = frame[3][thse_pkg::BATTERY_BIT];
    assign link_now    = frame[4][thse_pkg::LINK_BIT];

    always_comb
    begin
        frame_next   = frame;
        changed_next = 1'b0;
        case (thse_pkg::cmd_t'(item.command))
            thse_pkg::CMD_SHOW:
            begin
                frame_next   = show_frame;
                changed_next = 1'b1;
            end
            thse_pkg::CMD_BATTERY:
            begin
                frame_next[3][thse_pkg::BATTERY_BIT] = item.icon_on;
                changed_next = (battery_now != item.icon_on);
            end
            thse_pkg::CMD_LINK:
            begin
                frame_next[4][thse_pkg::LINK_BIT] = item.icon_on;
                changed_next = (link_now != item.icon_on);
            end
            default:
            begin
                frame_next   = frame;
                changed_next = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
